// ===== hw/rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// Used by every module under hw/rtl; depends on nothing.
package uer_pkg;

  localparam int TrigWidthW = 8;
  localparam int RiseToW    = 19;
  localparam int FallToW    = 15;
  localparam int WaitW      = 19;
  localparam int ElapsedW   = 15;
  localparam int DistW      = 10;
  localparam int UnitW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 19;

  localparam logic [TrigWidthW-1:0] TRIG_WIDTH_RST = 8'd10;
  localparam logic [RiseToW-1:0]    RISE_TO_RST    = 19'd500000;
  localparam logic [FallToW-1:0]    FALL_TO_RST    = 15'd30000;

  localparam logic [ElapsedW-1:0] ELAPSED_MAX = 15'd32767;

  // floor(x/58) = (x * 36158) >> 21 and floor(x/148) = (x * 56681) >> 23
  // are exact for every 15-bit x.
  localparam logic [15:0] CM_RECIP   = 16'd36158;
  localparam int          CM_SHIFT   = 21;
  localparam logic [15:0] INCH_RECIP = 16'd56681;
  localparam int          INCH_SHIFT = 23;

  localparam logic [UnitW-1:0] UNIT_CM   = 2'd0;
  localparam logic [UnitW-1:0] UNIT_INCH = 2'd1;

  localparam logic [CfgIdxW-1:0] CFG_TRIG_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RISE_TO    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALL_TO    = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef struct packed {
    logic [TrigWidthW-1:0] trigger_width;
    logic [RiseToW-1:0]    rise_timeout;
    logic [FallToW-1:0]    fall_timeout;
  } cfg_t;

  typedef struct packed {
    logic             error;
    logic [DistW-1:0] distance;
    logic             done_res;
    logic             busy_res;
    logic             trig;
  } res_t;

endpackage

// ===== hw/rtl/uer_cfg_regs.sv =====
// Configuration register file: trigger width and the two wait timeouts.
// Depends on uer_pkg.
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width <= TRIG_WIDTH_RST;
      cfg.rise_timeout  <= RISE_TO_RST;
      cfg.fall_timeout  <= FALL_TO_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TRIG_WIDTH: cfg.trigger_width <= wr_data[TrigWidthW-1:0];
        CFG_RISE_TO:    cfg.rise_timeout  <= wr_data[RiseToW-1:0];
        CFG_FALL_TO:    cfg.fall_timeout  <= wr_data[FallToW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/uer_dist.sv =====
// Converts the echo length in ticks to cm or inches by reciprocal multiply.
// Depends on uer_pkg.
module uer_dist
  import uer_pkg::*;
(
  input  logic [ElapsedW-1:0] ticks,
  input  logic [UnitW-1:0]    unit,
  output logic [DistW-1:0]    distance
);

  logic [ElapsedW+15:0] cm_prod;
  logic [ElapsedW+15:0] inch_prod;

  assign cm_prod   = {16'd0, ticks} * {{ElapsedW{1'b0}}, CM_RECIP};
  assign inch_prod = {16'd0, ticks} * {{ElapsedW{1'b0}}, INCH_RECIP};

  always_comb begin
    case (unit)
      UNIT_CM:   distance = cm_prod[CM_SHIFT +: DistW];
      UNIT_INCH: distance = {2'b00, inch_prod[INCH_SHIFT +: DistW-2]};
      default:   distance = '0;
    endcase
  end

endmodule

// ===== hw/rtl/uer_seq.sv =====
// Measurement sequencer: trigger, rise wait and fall wait, one step per beat.
// Depends on uer_pkg and uer_dist.
module uer_seq
  import uer_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             op,
  input  logic             echo,
  input  logic [UnitW-1:0] unit,
  input  cfg_t             cfg,
  output res_t             res
);

  phase_t               phase, phase_next;
  logic [WaitW-1:0]     wait_count, wait_count_next;
  logic [ElapsedW-1:0]  elapsed, elapsed_next;
  logic                 error_seen, error_seen_next;
  logic [UnitW-1:0]     unit_held, unit_held_next;
  logic                 last_echo;

  logic                 change;
  logic [WaitW-1:0]     wait_inc;
  logic                 done;
  logic [DistW-1:0]     conv_dist;

  assign change   = echo ^ last_echo;
  assign wait_inc = wait_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    elapsed_next    = elapsed;
    error_seen_next = error_seen;
    unit_held_next  = unit_held;
    done            = 1'b0;
    if (op) begin
      unit_held_next  = unit;
      phase_next      = PH_TRIG;
      wait_count_next = '0;
      elapsed_next    = '0;
      error_seen_next = 1'b0;
    end else begin
      case (phase)
        PH_TRIG: begin
          wait_count_next = wait_inc;
          if (wait_inc >= {{(WaitW-TrigWidthW){1'b0}}, cfg.trigger_width}) begin
            phase_next      = PH_RISE;
            wait_count_next = '0;
          end
        end
        PH_RISE: begin
          if (change) begin
            phase_next      = PH_FALL;
            wait_count_next = '0;
            elapsed_next    = '0;
          end else if (wait_inc >= cfg.rise_timeout) begin
            error_seen_next = 1'b1;
            phase_next      = PH_FALL;
            wait_count_next = '0;
            elapsed_next    = '0;
          end else begin
            wait_count_next = wait_inc;
          end
        end
        PH_FALL: begin
          if (elapsed != ELAPSED_MAX) elapsed_next = elapsed + 1'b1;
          if (change) begin
            done = 1'b1;
          end else if (wait_inc >= {{(WaitW-FallToW){1'b0}}, cfg.fall_timeout}) begin
            error_seen_next = 1'b1;
            done            = 1'b1;
          end else begin
            wait_count_next = wait_inc;
          end
          if (done) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  uer_dist u_dist (
    .ticks    (elapsed_next),
    .unit     (unit_held),
    .distance (conv_dist)
  );

  always_comb begin
    res.trig     = (phase_next == PH_TRIG);
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.error    = done & error_seen_next;
    res.distance = (done && !error_seen_next) ? conv_dist : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      elapsed    <= '0;
      error_seen <= 1'b0;
      unit_held  <= '0;
      last_echo  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      elapsed    <= elapsed_next;
      error_seen <= error_seen_next;
      unit_held  <= unit_held_next;
      last_echo  <= echo;
    end
  end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger, top level: input register, sequencer, result register.
// Depends on uer_pkg, uer_cfg_regs, uer_seq.
//
// Usage: feed one beat per microsecond tick on s_*. s_tuser = 1 starts a
// measurement (unit taken from s_tdata), s_tuser = 0 is a plain tick. Every
// input beat gives exactly one result beat on m_*: trigger level, busy, a
// done pulse and, with done, the distance (cm, inches or 0) and error flag.
// A beat passes the input register, then the result register; throughput is one
// beat per cycle while m_tready is high, set by the sequencer step between them.
// When m_tready is low the result register holds, the input register fills,
// then s_tready drops; no beat is lost. The cfg channel is always ready and
// writes trigger_width (0), rise_timeout (1), fall_timeout (2); write it only
// while no measurement is running. Synchronous reset empties both registers,
// sets the sequencer idle and loads the register defaults (10, 500000, 30000).
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [0] echo, [2:1] unit, [7:3] zero
  input  logic                s_tuser,   // [0] op
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // [0] trig, [1] busy_res, [2] done_res,
                                         // [12:3] distance, [13] error, [15:14] zero
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t             cfg;
  res_t             res;
  res_t             out_res;

  logic             in_valid;
  logic             in_op;
  logic             in_echo;
  logic [UnitW-1:0] in_unit;
  logic             out_free;
  logic             step;

  assign cfg_ready = 1'b1;

  uer_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_echo <= s_tdata[0];
      in_unit <= s_tdata[2:1];
    end
  end

  uer_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .op   (in_op),
    .echo (in_echo),
    .unit (in_unit),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res <= res;
  end

  assign m_tdata = {2'b00, out_res.error, out_res.distance, out_res.done_res,
                    out_res.busy_res, out_res.trig};

endmodule

// ===== sim/tb_ultrasonic_echo_ranger.sv =====
// Self-checking testbench for ultrasonic_echo_ranger: random tick/start beats in, result beats
// checked against a cycle-free predictor of the ranging sequencer.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;
  localparam logic [UnitW-1:0] UNIT_NONE = 2'd2;
  localparam logic [UnitW-1:0] UNIT_RSVD = 2'd3;
  localparam int CM_DIV      = 58;
  localparam int INCH_DIV    = 148;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic             op;
    logic             echo;
    logic [UnitW-1:0] unit;
  } tick_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state and register copy
  phase_t              ph = PH_IDLE;
  logic [WaitW-1:0]    wcnt = '0;
  logic [ElapsedW-1:0] elap = '0;
  logic                err_seen = 1'b0;
  logic [UnitW-1:0]    unit_q = '0;
  logic                echo_q = 1'b0;
  logic [TrigWidthW-1:0] cfg_tw   = TRIG_WIDTH_RST;
  logic [RiseToW-1:0]    cfg_rise = RISE_TO_RST;
  logic [FallToW-1:0]    cfg_fall = FALL_TO_RST;

  tick_t pending_ticks[$];
  res_t  pending_results[$];
  tick_t next_tick;
  res_t  want_res;
  res_t  got_res;
  logic  in_beat = 1'b0;
  logic  echo_level = 1'b0;
  int    ticks_queued = 0;
  int    fail_count = 0;
  int    cycle_count = 0;
  int    snd_idle = 0;
  int    rcv_idle = 0;

  ultrasonic_echo_ranger u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [0] echo, [2:1] unit, [7:3] zero
    .s_tuser   (s_tuser),   // [0] op
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [0] trig, [1] busy_res, [2] done_res, [12:3] distance, [13] error
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic res_t ranger_step(logic op, logic echo, logic [UnitW-1:0] unit);
    res_t r;
    logic change;
    logic go;
    logic fin;
    r = '0;
    change = (echo != echo_q);
    go = change;
    fin = 1'b0;
    if (op == OP_START) begin
      unit_q = unit;
      ph = PH_TRIG;
      wcnt = '0;
      elap = '0;
      err_seen = 1'b0;
    end else begin
      case (ph)
        PH_TRIG: begin
          wcnt = wcnt + 1'b1;
          if (wcnt >= cfg_tw) begin
            ph = PH_RISE;
            wcnt = '0;
          end
        end
        PH_RISE: begin
          if (!go) begin
            wcnt = wcnt + 1'b1;
            if (wcnt >= cfg_rise) begin
              err_seen = 1'b1;
              go = 1'b1;
            end
          end
          if (go) begin
            ph = PH_FALL;
            wcnt = '0;
            elap = '0;
          end
        end
        PH_FALL: begin
          if (elap != ELAPSED_MAX) elap = elap + 1'b1;
          if (change) begin
            fin = 1'b1;
          end else begin
            wcnt = wcnt + 1'b1;
            if (wcnt >= cfg_fall) begin
              err_seen = 1'b1;
              fin = 1'b1;
            end
          end
          if (fin) begin
            ph = PH_IDLE;
            wcnt = '0;
            r.error = err_seen;
            if (err_seen) r.distance = '0;
            else if (unit_q == UNIT_CM) r.distance = DistW'(int'(elap) / CM_DIV);
            else if (unit_q == UNIT_INCH) r.distance = DistW'(int'(elap) / INCH_DIV);
            else r.distance = '0;
          end
        end
        default: ;
      endcase
    end
    echo_q = echo;
    r.trig = (ph == PH_TRIG);
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // sample at the rising edge: predict on input beats, check result beats
  always @(posedge clk) begin
    in_beat = s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expected result");
          fail_count++;
        end else begin
          want_res = pending_results.pop_front();
          got_res = res_t'(m_tdata[13:0]);
          check_field("trig", 16'(want_res.trig), 16'(got_res.trig));
          check_field("busy_res", 16'(want_res.busy_res), 16'(got_res.busy_res));
          check_field("done_res", 16'(want_res.done_res), 16'(got_res.done_res));
          check_field("distance", 16'(want_res.distance), 16'(got_res.distance));
          check_field("error", 16'(want_res.error), 16'(got_res.error));
          check_field("pad", 16'd0, 16'(m_tdata[15:14]));
        end
      end
      if (in_beat)
        pending_results.push_back(ranger_step(s_tuser, s_tdata[0], s_tdata[2:1]));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_beat) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle) begin
          next_tick = pending_ticks.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_tick.op;
          s_tdata  <= {5'b0, next_tick.unit, next_tick.echo};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic queue_beat(logic op, logic echo, logic [UnitW-1:0] unit);
    tick_t t;
    t.op = op;
    t.echo = echo;
    t.unit = unit;
    pending_ticks.push_back(t);
    echo_level = echo;
    ticks_queued++;
  endtask

  // start, trigger ticks with a noisy echo, rise gap, echo edge, fall length, echo edge
  task automatic measure(logic [UnitW-1:0] unit, int rise_gap, int fall_len);
    int trig_ticks;
    trig_ticks = (cfg_tw == 0) ? 1 : int'(cfg_tw);
    queue_beat(OP_START, 1'($urandom_range(1)), unit);
    repeat (trig_ticks) queue_beat(OP_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)));
    repeat (rise_gap) queue_beat(OP_TICK, echo_level, 2'($urandom_range(3)));
    queue_beat(OP_TICK, ~echo_level, 2'($urandom_range(3)));
    repeat (fall_len - 1) queue_beat(OP_TICK, echo_level, 2'($urandom_range(3)));
    queue_beat(OP_TICK, ~echo_level, 2'($urandom_range(3)));
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // hold the sender until all results are back, then toggle echo until idle
  task automatic settle();
    drain();
    while (ph != PH_IDLE) begin
      repeat (4) queue_beat(OP_TICK, ~echo_level, 2'($urandom_range(3)));
      drain();
    end
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TRIG_WIDTH: cfg_tw   = data[TrigWidthW-1:0];
      CFG_RISE_TO:    cfg_rise = data[RiseToW-1:0];
      CFG_FALL_TO:    cfg_fall = data[FallToW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int tw, int rise, int fall);
    write_cfg(CFG_TRIG_WIDTH, CfgDataW'(tw));
    write_cfg(CFG_RISE_TO, CfgDataW'(rise));
    write_cfg(CFG_FALL_TO, CfgDataW'(fall));
  endtask

  task automatic random_regs();
    set_regs($urandom_range(12, 1), $urandom_range(40, 1), $urandom_range(80, 20));
  endtask

  task automatic random_phase(int budget);
    int first;
    int rise_cap;
    int fall_cap;
    int pick;
    first = ticks_queued;
    rise_cap = (int'(cfg_rise) + 2 < 40) ? int'(cfg_rise) + 2 : 40;
    fall_cap = (int'(cfg_fall) + 2 < 90) ? int'(cfg_fall) + 2 : 90;
    while (ticks_queued - first < budget) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        measure(2'($urandom_range(3)), $urandom_range(rise_cap), $urandom_range(20, 1));
      end else if (pick < 7) begin
        measure(2'($urandom_range(3)), $urandom_range(rise_cap), $urandom_range(fall_cap, 1));
      end else if (pick == 7) begin
        repeat ($urandom_range(6, 1))
          queue_beat(OP_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)));
      end else begin
        // broken sequence: a start and up to five random ticks
        queue_beat(OP_START, 1'($urandom_range(1)), 2'($urandom_range(3)));
        repeat ($urandom_range(5))
          queue_beat(OP_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)));
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle = 14;
    rcv_idle = 70;
    // reset register values: idle ticks, then one cm and one inch reading
    queue_beat(OP_TICK, 1'b1, UNIT_RSVD);
    queue_beat(OP_TICK, 1'b0, UNIT_CM);
    measure(UNIT_CM, 0, 58);
    measure(UNIT_INCH, 3, 148);
    settle();

    set_regs(1, 1, 1);
    measure(UNIT_NONE, 0, 1);
    measure(UNIT_RSVD, 0, 1);
    measure(UNIT_CM, 1, 1);    // rise timeout
    measure(UNIT_INCH, 0, 2);  // fall timeout
    queue_beat(OP_START, 1'b0, UNIT_CM);
    queue_beat(OP_START, 1'b1, UNIT_INCH);  // restart during trigger
    queue_beat(OP_TICK, 1'b1, UNIT_CM);
    queue_beat(OP_TICK, 1'b0, UNIT_CM);     // now in fall wait
    measure(UNIT_INCH, 0, 1);               // restart during fall wait
    settle();

    set_regs(0, 0, 0);
    measure(UNIT_CM, 0, 1);
    measure(UNIT_INCH, 3, 3);
    settle();

    random_regs();
    random_phase(25);

    snd_idle = 70;
    rcv_idle = 14;
    random_regs();
    random_phase(25);

    snd_idle = 0;
    rcv_idle = 0;
    random_regs();
    random_phase(25);

    // widest timeouts with a short trigger
    set_regs(1, 524287, 32767);
    measure(UNIT_CM, 2, 3);
    measure(UNIT_INCH, 0, 3);
    settle();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/uer_pkg.sv
hw/rtl/uer_cfg_regs.sv
hw/rtl/uer_dist.sv
hw/rtl/uer_seq.sv
hw/rtl/ultrasonic_echo_ranger.sv
sim/tb_ultrasonic_echo_ranger.sv
